### hdl/mbps_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbps_pkg: shared types and constants for the masked byte pattern search
// Beat structs, configuration register indexes and the register bundle.
// ----------------------------------------------------------------------------
package mbps_pkg;

    localparam int ADDR_BITS     = 48;
    localparam int PATTERN_BYTES = 16;
    localparam int CFG_DATA_W    = 64;
    localparam int CFG_IDX_W     = 3;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_LOW  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_HIGH = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CARE_MASK    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_LEN  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_BACKWARD     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_FIRST_START  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_LAST_START   = 3'd6;

    typedef struct packed {
        logic [7:0]           mem_byte;
        logic [ADDR_BITS-1:0] byte_address;
        logic                 last_byte;
    } in_beat_t;

    typedef struct packed {
        logic [ADDR_BITS-1:0] match_address;
        logic                 found;
    } out_beat_t;

    typedef struct packed {
        logic [63:0]              pattern_low_bytes;
        logic [63:0]              pattern_high_bytes;
        logic [PATTERN_BYTES-1:0] care_mask;
        logic                     search_backward;
        logic [ADDR_BITS-1:0]     first_start;
        logic [ADDR_BITS-1:0]     last_start;
    } cfg_t;

endpackage

### hdl/masked_byte_pattern_search.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// masked_byte_pattern_search: wildcard byte signature scan
// Streams memory bytes, compares a sliding window with a masked pattern and
// reports the first (forward) or last (backward) in-range match at the end
// of each scan.
// ----------------------------------------------------------------------------
//
//  Channel | Signals                          | Direction | Beat
//  --------+----------------------------------+-----------+---------------------
//  in      | in_valid, in_stall, in_data      | sink      | byte, address, last
//  out     | out_valid, out_stall, out_data   | source    | address, found
//  cfg     | cfg_we, cfg_index, cfg_data      | sink      | register write
//
//  - One byte is taken every cycle while in_stall is low; the masked
//    compare is a fixed parallel check of the window: one beat per clock.
//  - out_valid rises once the last byte has passed from the input-stage
//    registers through the compare into the output register; a result
//    waiting in the output register can hold that byte in the input stage.
//  - in_stall rises only when a second last byte reaches the compare stage
//    while the previous result still waits in the output register.
//  - Reset clears the scan state and sets the pattern length to one; the
//    other config registers reset to zero; window and payload are not reset.
//
// ----------------------------------------------------------------------------
module masked_byte_pattern_search
    import mbps_pkg::*;
#(
    parameter int MAX_PATTERN_BYTES = 16
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  in_beat_t              in_data,
    output logic                  out_valid,
    input  logic                  out_stall,
    output out_beat_t             out_data
);

    localparam int LEN_W = $clog2(MAX_PATTERN_BYTES + 1);

    cfg_t                              cfg;
    logic [LEN_W-1:0]                  eff_len;
    logic [MAX_PATTERN_BYTES-1:0][7:0] window;
    logic [ADDR_BITS-1:0]              start_addr;
    logic                              enough;
    logic                              s1_last;
    logic                              hit;

    logic                              in_accept;
    logic                              s1_valid_reg;
    logic                              s1_go;
    logic                              take;

    logic [ADDR_BITS-1:0]              best_address_reg;
    logic                              have_match_reg;
    logic                              out_valid_reg;
    out_beat_t                         out_reg;

    mbps_cfg_regs #(
        .MAX_PATTERN_BYTES (MAX_PATTERN_BYTES),
        .LEN_W             (LEN_W)
    ) u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg),
        .eff_len   (eff_len)
    );

    mbps_window #(
        .MAX_PATTERN_BYTES (MAX_PATTERN_BYTES),
        .LEN_W             (LEN_W)
    ) u_window (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (in_accept),
        .beat       (in_data),
        .eff_len    (eff_len),
        .window     (window),
        .start_addr (start_addr),
        .enough     (enough),
        .last       (s1_last)
    );

    mbps_compare #(
        .MAX_PATTERN_BYTES (MAX_PATTERN_BYTES),
        .LEN_W             (LEN_W)
    ) u_compare (
        .window     (window),
        .start_addr (start_addr),
        .enough     (enough),
        .cfg        (cfg),
        .eff_len    (eff_len),
        .hit        (hit)
    );

    // Compare stage moves on unless it holds a last byte and the output
    // register is full and not being drained this cycle.
    assign s1_go     = s1_valid_reg && !(s1_last && out_valid_reg && out_stall);
    assign in_stall  = s1_valid_reg && !s1_go;
    assign in_accept = in_valid && !in_stall;

    // forward mode keeps the first hit, backward mode every later one
    assign take = hit && (cfg.search_backward || !have_match_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg     <= 1'b0;
            have_match_reg   <= 1'b0;
            best_address_reg <= '0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= in_accept || (s1_valid_reg && !s1_go);

            // a new result may replace one drained in the same cycle
            if (s1_go && s1_last)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;

            if (s1_go)
            begin
                if (s1_last)
                begin
                    // scan ends: report and clear for the next region
                    have_match_reg   <= 1'b0;
                    best_address_reg <= '0;
                end
                else if (take)
                begin
                    have_match_reg   <= 1'b1;
                    best_address_reg <= start_addr;
                end
            end
        end
    end

    // result payload, loaded only when a scan ends
    always_ff @(posedge clk)
    begin
        if (s1_go && s1_last)
        begin
            out_reg.found         <= take || have_match_reg;
            out_reg.match_address <= take ? start_addr
                                   : (have_match_reg ? best_address_reg : '0);
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    // a new result only follows a last byte leaving the compare stage
    a_result_from_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !$past(out_valid_reg)) |-> $past(s1_go && s1_last))
        else $error("result raised without a last byte");

    // input holds off only for a last byte blocked behind a waiting result
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (s1_last && out_valid_reg && out_stall))
        else $error("input stalled without a blocked result");

    // scan state is cleared after the end of a scan
    a_scan_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_go && s1_last) |=> (!have_match_reg && best_address_reg == '0))
        else $error("scan state not cleared");

    // forward mode never replaces a held match within a scan
    a_forward_keeps: assert property (@(posedge clk) disable iff (!rst_n)
        (have_match_reg && !cfg.search_backward && s1_go && !s1_last)
            |=> $stable(best_address_reg))
        else $error("forward match overwritten");

endmodule

### hdl/mbps_cfg_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbps_cfg_regs: configuration register file
// Holds the pattern, mask, range and mode; keeps the clamped pattern length.
// ----------------------------------------------------------------------------
module mbps_cfg_regs
    import mbps_pkg::*;
#(
    parameter int MAX_PATTERN_BYTES = 16,
    parameter int LEN_W             = 5
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output cfg_t                  cfg,
    output logic [LEN_W-1:0]      eff_len
);

    localparam int VW = (LEN_W > 5) ? LEN_W : 5;

    cfg_t             cfg_reg;
    logic [LEN_W-1:0] eff_len_reg;
    logic [VW-1:0]    len_value;
    logic [LEN_W-1:0] len_clamped;

    // zero acts as one, anything past the window depth acts as the depth
    always_comb
    begin
        len_value = VW'(cfg_data[4:0]);
        if (len_value == '0)
            len_clamped = LEN_W'(1);
        else if (len_value > VW'(MAX_PATTERN_BYTES))
            len_clamped = LEN_W'(MAX_PATTERN_BYTES);
        else
            len_clamped = len_value[LEN_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg     <= '0;
            eff_len_reg <= LEN_W'(1);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_PATTERN_LOW:  cfg_reg.pattern_low_bytes  <= cfg_data[63:0];
                CFG_PATTERN_HIGH: cfg_reg.pattern_high_bytes <= cfg_data[63:0];
                CFG_CARE_MASK:    cfg_reg.care_mask   <= cfg_data[PATTERN_BYTES-1:0];
                CFG_PATTERN_LEN:  eff_len_reg          <= len_clamped;
                CFG_BACKWARD:     cfg_reg.search_backward <= cfg_data[0];
                CFG_FIRST_START:  cfg_reg.first_start <= cfg_data[ADDR_BITS-1:0];
                CFG_LAST_START:   cfg_reg.last_start  <= cfg_data[ADDR_BITS-1:0];
                default:          ;
            endcase
        end
    end

    assign cfg     = cfg_reg;
    assign eff_len = eff_len_reg;

endmodule

### hdl/mbps_window.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbps_window: input stage
// Shifts each byte into the window, counts bytes of the scan, registers the
// window start address, the last flag and whether enough bytes have arrived.
// ----------------------------------------------------------------------------
module mbps_window
    import mbps_pkg::*;
#(
    parameter int MAX_PATTERN_BYTES = 16,
    parameter int LEN_W             = 5
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                load,
    input  in_beat_t                            beat,
    input  logic [LEN_W-1:0]                    eff_len,
    output logic [MAX_PATTERN_BYTES-1:0][7:0]   window,
    output logic [ADDR_BITS-1:0]                start_addr,
    output logic                                enough,
    output logic                                last
);

    logic [MAX_PATTERN_BYTES-1:0][7:0] window_reg;
    logic [MAX_PATTERN_BYTES-1:0][7:0] window_next;
    logic [LEN_W-1:0]                  seen_reg;
    logic [LEN_W-1:0]                  seen_inc;
    logic [LEN_W-1:0]                  len_m1;
    logic [ADDR_BITS-1:0]              start_reg;
    logic                              enough_reg;
    logic                              last_reg;

    always_comb
    begin
        window_next[0] = beat.mem_byte;
        for (int k = 1; k < MAX_PATTERN_BYTES; k++)
            window_next[k] = window_reg[k-1];
    end

    // saturating count of bytes in this scan
    assign seen_inc = (seen_reg == LEN_W'(MAX_PATTERN_BYTES)) ? seen_reg
                                                              : seen_reg + LEN_W'(1);
    assign len_m1   = eff_len - LEN_W'(1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            seen_reg <= '0;
        else if (load)
            seen_reg <= beat.last_byte ? '0 : seen_inc;
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            window_reg <= window_next;
            start_reg  <= beat.byte_address - ADDR_BITS'(len_m1);
            enough_reg <= (seen_inc >= eff_len);
            last_reg   <= beat.last_byte;
        end
    end

    assign window     = window_reg;
    assign start_addr = start_reg;
    assign enough     = enough_reg;
    assign last       = last_reg;

endmodule

### hdl/mbps_compare.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbps_compare: masked window compare and range check
// Flags a hit when enough bytes have arrived, the window matches the cared
// pattern bytes and its start lies inside the configured inclusive range.
// ----------------------------------------------------------------------------
module mbps_compare
    import mbps_pkg::*;
#(
    parameter int MAX_PATTERN_BYTES = 16,
    parameter int LEN_W             = 5
)
(
    input  logic [MAX_PATTERN_BYTES-1:0][7:0] window,
    input  logic [ADDR_BITS-1:0]              start_addr,
    input  logic                              enough,
    input  cfg_t                              cfg,
    input  logic [LEN_W-1:0]                  eff_len,
    output logic                              hit
);

    localparam int PB    = (MAX_PATTERN_BYTES < PATTERN_BYTES) ? MAX_PATTERN_BYTES
                                                               : PATTERN_BYTES;
    localparam int IDX_W = (MAX_PATTERN_BYTES > 1) ? $clog2(MAX_PATTERN_BYTES) : 1;

    logic [2*64-1:0]  pattern;
    logic [PB-1:0]    byte_ok;
    logic [LEN_W-1:0] pos;
    logic             in_range;

    assign pattern = {cfg.pattern_high_bytes, cfg.pattern_low_bytes};

    // pattern byte i lines up with window slot len-1-i (slot 0 is newest)
    always_comb
    begin
        byte_ok = '1;
        pos     = '0;
        for (int i = 0; i < PB; i++)
        begin
            pos = eff_len - LEN_W'(1) - LEN_W'(i);
            if (cfg.care_mask[i] && (LEN_W'(i) < eff_len))
                byte_ok[i] = (window[pos[IDX_W-1:0]] == pattern[8*i +: 8]);
        end
    end

    assign in_range = (start_addr >= cfg.first_start) && (start_addr <= cfg.last_start);
    assign hit      = enough && in_range && (&byte_ok);

endmodule

### tb/tb_masked_byte_pattern_search.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_masked_byte_pattern_search: self-checking bench for the pattern search
// Streams byte scans over the valid/stall channel and mirrors the masked
// window compare in a scoreboard model. Each result beat is checked against
// the oldest predicted match. Directed corners come first, then random scans
// under three receiver/sender idle mixes.
// ----------------------------------------------------------------------------
module tb_masked_byte_pattern_search;
    import mbps_pkg::*;

    localparam int CLK_HALF     = 5;
    localparam int RANDOM_BYTES = 1900;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int SETTLE_CYCLES = 4;

    // index 7 is not decoded; writes there must be ignored
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 3'd7;
    localparam logic [ADDR_BITS-1:0] ADDR_MAX   = '1;

    // one full register set, raw 64-bit write data per register
    typedef struct packed {
        logic [63:0] pat_lo;
        logic [63:0] pat_hi;
        logic [63:0] care;
        logic [63:0] len;
        logic [63:0] backward;
        logic [63:0] first;
        logic [63:0] last;
    } scan_setup_t;

    // ------------------------------------------------------------------------
    // DUT connections; every input starts at a known value
    // ------------------------------------------------------------------------
    logic                  clk;
    logic                  rst_n     = 1'b0;
    logic                  cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;
    logic                  in_valid  = 1'b0;
    logic                  in_stall;
    in_beat_t              in_data   = '0;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    out_beat_t             out_data;

    masked_byte_pattern_search #(
        .MAX_PATTERN_BYTES(PATTERN_BYTES)
    ) u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .in_data  (in_data),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .out_data (out_data)
    );

    // ------------------------------------------------------------------------
    // Scoreboard model: register mirror plus scan state
    // ------------------------------------------------------------------------
    logic [63:0]          pat_low       = '0;
    logic [63:0]          pat_high      = '0;
    logic [15:0]          care_bits     = '0;
    logic [4:0]           pat_len_raw   = 5'd1;
    logic                 backward_mode = 1'b0;
    logic [ADDR_BITS-1:0] range_lo      = '0;
    logic [ADDR_BITS-1:0] range_hi      = '0;

    logic [7:0]           win [PATTERN_BYTES];   // win[0] is the newest byte
    int                   seen_cnt;
    logic [ADDR_BITS-1:0] best_start;
    logic                 hit_seen;

    out_beat_t            pending_matches [$];
    int                   err_count   = 0;
    int unsigned          cycle_count = 0;
    int                   send_idle_pct;
    int                   stall_pct;

    // ------------------------------------------------------------------------
    // Helpers
    // ------------------------------------------------------------------------
    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // field in the low bits; now and then random junk above it
    function automatic logic [63:0] with_noise(logic [63:0] field, int width);
        logic [63:0] keep;
        keep = (64'd1 << width) - 64'd1;
        if ($urandom_range(3) == 0)
            return (rand64() & ~keep) | (field & keep);
        return field & keep;
    endfunction

    // length 0 behaves as 1, anything above 16 as 16
    function automatic int active_len();
        if (pat_len_raw == 5'd0)
            return 1;
        if (pat_len_raw > PATTERN_BYTES)
            return PATTERN_BYTES;
        return int'(pat_len_raw);
    endfunction

    task automatic clear_scan();
        int k;
        for (k = 0; k < PATTERN_BYTES; k++)
            win[k] = 8'h00;
        seen_cnt   = 0;
        best_start = '0;
        hit_seen   = 1'b0;
    endtask

    task automatic set_pressure(input int send_pct, input int recv_pct);
        send_idle_pct = send_pct;
        stall_pct     = recv_pct;
    endtask

    // Shift one accepted byte into the model window and queue a result
    // beat when the scan ends.
    task automatic advance_scan(input in_beat_t beat);
        int                   len;
        int                   k;
        logic                 hit;
        logic [127:0]         pattern_bytes;
        logic [ADDR_BITS-1:0] start;
        out_beat_t            res;
        pattern_bytes = {pat_high, pat_low};
        for (k = PATTERN_BYTES - 1; k > 0; k--)
            win[k] = win[k - 1];
        win[0] = beat.mem_byte;
        if (seen_cnt < PATTERN_BYTES)
            seen_cnt++;

        len = active_len();
        if (seen_cnt >= len)
        begin
            // window start wraps modulo 2^48
            start = beat.byte_address - ADDR_BITS'(len - 1);
            hit   = 1'b1;
            // pattern byte 0 lines up with the oldest byte of the window
            for (k = 0; k < len; k++)
                if (care_bits[k] && win[len - 1 - k] != pattern_bytes[8 * k +: 8])
                    hit = 1'b0;
            if (hit && start >= range_lo && start <= range_hi
                    && (backward_mode || !hit_seen))
            begin
                best_start = start;
                hit_seen   = 1'b1;
            end
        end

        if (beat.last_byte)
        begin
            res.match_address = hit_seen ? best_start : '0;
            res.found         = hit_seen;
            pending_matches.insert(pending_matches.size(), res);
            clear_scan();
        end
    endtask

    // ------------------------------------------------------------------------
    // Input channel: random idle gaps, payload held until taken
    // ------------------------------------------------------------------------
    task automatic send_beat(input logic [7:0] data_byte,
                             input logic [ADDR_BITS-1:0] addr,
                             input logic is_last);
        in_beat_t beat;
        beat.mem_byte     = data_byte;
        beat.byte_address = addr;
        beat.last_byte    = is_last;
        while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= beat;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        advance_scan(beat);
    endtask

    // Drop valid, wait for every predicted beat, then let the pipe settle
    // so nothing is in flight when the registers change.
    task automatic wait_scan_idle();
        in_valid <= 1'b0;
        while (pending_matches.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        case (idx)
            CFG_PATTERN_LOW:  pat_low       = value;
            CFG_PATTERN_HIGH: pat_high      = value;
            CFG_CARE_MASK:    care_bits     = value[15:0];
            CFG_PATTERN_LEN:  pat_len_raw   = value[4:0];
            CFG_BACKWARD:     backward_mode = value[0];
            CFG_FIRST_START:  range_lo      = value[ADDR_BITS-1:0];
            CFG_LAST_START:   range_hi      = value[ADDR_BITS-1:0];
            default: ;
        endcase
    endtask

    // full register set, written only once the block has gone quiet
    task automatic program_scan(input scan_setup_t s, input bit poke_unused);
        wait_scan_idle();
        write_reg(CFG_PATTERN_LOW, s.pat_lo);
        write_reg(CFG_PATTERN_HIGH, s.pat_hi);
        write_reg(CFG_CARE_MASK, s.care);
        write_reg(CFG_PATTERN_LEN, s.len);
        write_reg(CFG_BACKWARD, s.backward);
        write_reg(CFG_FIRST_START, s.first);
        write_reg(CFG_LAST_START, s.last);
        if (poke_unused)
            write_reg(CFG_UNUSED, 64'd1);
        cfg_we <= 1'b0;
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Reset values: length 1, all wildcards, range [0,0]. Only the byte at
    // address 0 can start a match.
    task automatic test_reset_defaults();
        send_beat(8'h00, 48'h0, 1'b0);
        send_beat(8'hFF, 48'h1, 1'b1);
    endtask

    // Two-byte pattern with a wildcard second byte and two hits in range:
    // forward keeps the lower start, backward the higher one.
    task automatic test_search_direction();
        scan_setup_t setup;
        int          dir;
        setup       = '0;
        setup.pat_lo = 64'h0000_0000_0000_00A5;
        setup.care  = 64'h1;
        setup.len   = 64'd2;
        setup.first = 64'h1000;
        setup.last  = 64'h1002;
        for (dir = 0; dir < 2; dir++)
        begin
            setup.backward = 64'(dir);
            program_scan(setup, 1'b0);
            send_beat(8'hA5, 48'h1000, 1'b0);
            send_beat(8'h00, 48'h1001, 1'b0);
            send_beat(8'hA5, 48'h1002, 1'b0);
            send_beat(8'hFF, 48'h1003, 1'b1);
        end
    endtask

    task automatic test_corner_cases();
        scan_setup_t setup;

        // length 0 acts as 1; top address, all-ones byte
        setup        = '0;
        setup.pat_lo = 64'hFF;
        setup.care   = 64'h1;
        setup.first  = 64'(ADDR_MAX);
        setup.last   = 64'(ADDR_MAX);
        program_scan(setup, 1'b0);
        send_beat(8'hFF, ADDR_MAX, 1'b1);

        // window straddles the address wrap: start lands on the top address
        setup.pat_lo = 64'h3412;
        setup.care   = 64'h3;
        setup.len    = 64'd2;
        program_scan(setup, 1'b0);
        send_beat(8'h12, ADDR_MAX, 1'b0);
        send_beat(8'h34, 48'h0, 1'b1);

        // empty range: first above last, nothing qualifies
        setup        = '0;
        setup.len    = 64'd1;
        setup.first  = 64'd5;
        setup.last   = 64'd4;
        program_scan(setup, 1'b0);
        send_beat(8'h00, 48'h5, 1'b1);

        // length 31 clamps to 16; one byte is too few for any compare.
        // The stray write to the undecoded index must not alias a register.
        setup        = '0;
        setup.len    = 64'd31;
        setup.first  = 64'd0;
        setup.last   = 64'(ADDR_MAX);
        program_scan(setup, 1'b1);
        send_beat(8'hAA, 48'h100, 1'b1);
    endtask

    // Random scans: mostly contiguous byte runs with planted pattern copies,
    // some with address jumps. Registers change between scans about half the
    // time; otherwise scans run back to back so result beats can pile up.
    task automatic test_random_scans();
        scan_setup_t          setup;
        logic [ADDR_BITS-1:0] base_addr;
        logic [ADDR_BITS-1:0] addr;
        logic [ADDR_BITS-1:0] lo;
        logic [ADDR_BITS-1:0] hi;
        logic [7:0]           scan_bytes [$];
        logic [127:0]         pattern_bytes;
        int                   sent;
        int                   n;
        int                   len;
        int                   pos;
        int                   sel;
        int                   i;
        int                   j;
        sent      = 0;
        n         = 0;
        base_addr = '0;
        while (sent < RANDOM_BYTES)
        begin
            if (sent < RANDOM_BYTES / 3)
                set_pressure(18, 66);
            else if (sent < 2 * RANDOM_BYTES / 3)
                set_pressure(66, 18);
            else
                set_pressure(0, 0);

            if (sent == 0 || $urandom_range(1) == 1)
            begin
                // region: near the top (wrap), near zero, or anywhere
                sel = $urandom_range(99);
                if (sel < 15)
                    base_addr = ADDR_MAX - ADDR_BITS'($urandom_range(40));
                else if (sel < 30)
                    base_addr = ADDR_BITS'($urandom_range(40));
                else
                    base_addr = ADDR_BITS'(rand64());

                setup.pat_lo = rand64();
                setup.pat_hi = rand64();

                sel = $urandom_range(99);
                if (sel < 25)
                    setup.care = with_noise(64'hFFFF, 16);
                else if (sel < 35)
                    setup.care = with_noise(64'h0, 16);
                else
                    setup.care = with_noise(64'($urandom_range(65535)), 16);

                // mostly short patterns; 0, 16 and the clamped values too
                sel = $urandom_range(99);
                if (sel < 10)
                    setup.len = with_noise(64'd0, 5);
                else if (sel < 20)
                    setup.len = with_noise(64'(17 + $urandom_range(14)), 5);
                else if (sel < 35)
                    setup.len = with_noise(64'd16, 5);
                else
                    setup.len = with_noise(64'(1 + $urandom_range(7)), 5);

                setup.backward = with_noise(64'($urandom_range(1)), 1);

                sel = $urandom_range(99);
                if (sel < 55)
                begin
                    lo = base_addr - ADDR_BITS'($urandom_range(3));
                    hi = base_addr + ADDR_BITS'($urandom_range(50));
                end
                else if (sel < 70)
                begin
                    lo = '0;
                    hi = ADDR_MAX;
                end
                else if (sel < 80)
                begin
                    // first above last
                    lo = base_addr + ADDR_BITS'(10 + $urandom_range(20));
                    hi = base_addr + ADDR_BITS'($urandom_range(9));
                end
                else if (sel < 90)
                begin
                    lo = base_addr + ADDR_BITS'($urandom_range(20));
                    hi = lo;
                end
                else
                begin
                    lo = ADDR_BITS'(rand64());
                    hi = ADDR_BITS'(rand64());
                end
                setup.first = with_noise(64'(lo), ADDR_BITS);
                setup.last  = with_noise(64'(hi), ADDR_BITS);
                program_scan(setup, $urandom_range(9) == 0);
            end
            else if ($urandom_range(1) == 1)
                base_addr = base_addr + ADDR_BITS'(n);   // next region up

            len           = active_len();
            pattern_bytes = {pat_high, pat_low};

            // short scans stack up last bytes and exercise in_stall
            sel = $urandom_range(99);
            if (sel < 20)
                n = 1 + $urandom_range(2);
            else if (sel < 90)
                n = 4 + $urandom_range(36);
            else
                n = 41 + $urandom_range(23);

            scan_bytes.delete();
            repeat (n) scan_bytes.insert(scan_bytes.size(), 8'($urandom_range(255)));
            // plant copies; wildcard positions keep their random bytes
            repeat ($urandom_range(3))
                if (n >= len)
                begin
                    pos = $urandom_range(n - len);
                    for (j = 0; j < len; j++)
                        if (care_bits[j])
                            scan_bytes[pos + j] = pattern_bytes[8 * j +: 8];
                end

            sel  = $urandom_range(99);
            addr = base_addr;
            for (i = 0; i < n; i++)
            begin
                send_beat(scan_bytes[i], addr, i == n - 1);
                if (sel < 85)
                    addr = addr + ADDR_BITS'(1);
                else if (sel < 95)
                    addr = addr + ADDR_BITS'($urandom_range(3));
                else
                    addr = ADDR_BITS'(rand64());
            end
            sent += n;
        end
    endtask

    // ------------------------------------------------------------------------
    // Clock, timeout, result check
    // ------------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
        forever #CLK_HALF clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("[masked_byte_pattern_search] ERROR");
            $finish;
        end
    end

    // Values read here are the pre-edge ones: all drivers use nonblocking
    // updates. The random stall for the next cycle is picked after the check.
    always @(posedge clk)
    begin : result_check
        out_beat_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_matches.size() == 0)
            begin
                $error("result beat with no scan pending: match_address %h found %b",
                       out_data.match_address, out_data.found);
                err_count++;
            end
            else
            begin
                want = pending_matches.pop_front();
                if (out_data.match_address !== want.match_address)
                begin
                    $error("match_address: expected %h, got %h",
                           want.match_address, out_data.match_address);
                    err_count++;
                end
                if (out_data.found !== want.found)
                begin
                    $error("found: expected %b, got %b", want.found, out_data.found);
                    err_count++;
                end
            end
        end
        out_stall <= (stall_pct > 0) && ($urandom_range(99) < stall_pct);
    end

    // ------------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------------
    initial
    begin
        clear_scan();
        set_pressure(18, 66);
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_defaults();
        test_search_direction();
        test_corner_cases();
        test_random_scans();

        wait_scan_idle();
        if (err_count == 0)
            $display("[masked_byte_pattern_search] OK");
        else
            $display("[masked_byte_pattern_search] ERROR");
        $finish;
    end

endmodule

### sim.f
hdl/mbps_pkg.sv
hdl/mbps_cfg_regs.sv
hdl/mbps_window.sv
hdl/mbps_compare.sv
hdl/masked_byte_pattern_search.sv
tb/tb_masked_byte_pattern_search.sv
